>>> rtl/bitmap_set_clear_find_engine_assert.svh
// ----------------------------------------------------------------------------
// bitmap set/clear/find engine assertion macros
// shared property forms for the engine's concurrent checks
// ----------------------------------------------------------------------------
`ifndef BITMAP_SET_CLEAR_FIND_ENGINE_ASSERT_SVH
`define BITMAP_SET_CLEAR_FIND_ENGINE_ASSERT_SVH

// same-cycle implication
`define BSC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bitmap engine check failed");

// next-cycle implication
`define BSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bitmap engine check failed");

`endif

>>> rtl/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// types and constants shared by the bitmap set/clear/find engine
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int ACT_W   = 3;
    localparam int IDX_W   = 12;
    localparam int BYTES_W = 10;
    localparam int SIZE_W  = 13;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

    typedef enum logic [ACT_W-1:0] {
        ACT_TEST      = 3'd0,
        ACT_SET       = 3'd1,
        ACT_CLEAR     = 3'd2,
        ACT_FIND_SET  = 3'd3,
        ACT_FIND_ZERO = 3'd4,
        ACT_COUNT     = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_RMW_RD,
        S_RMW_WR,
        S_PRIME,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [IDX_W-1:0]   bit_index;
        logic [BYTES_W-1:0] byte_count;
    } t_req;

    typedef struct packed {
        logic              old_bit;
        logic [SIZE_W-1:0] found_position;
        logic [SIZE_W-1:0] set_count;
    } t_rsp;

    typedef logic [SIZE_W-1:0] t_cfg;

endpackage

>>> rtl/bsc_stream_if.sv
// ----------------------------------------------------------------------------
// bsc_stream_if
// valid/ready channel carrying one payload item per handshake
// ----------------------------------------------------------------------------
interface bsc_stream_if #(
    parameter type T_PAYLOAD = logic
) ();
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/bsc_ram.sv
// ----------------------------------------------------------------------------
// bsc_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module bsc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bsc_div.sv
// ----------------------------------------------------------------------------
// bsc_div
// splits a bit index into word and bit by reciprocal multiplication
// ----------------------------------------------------------------------------
module bsc_div import bsc_pkg::*; #(
    parameter int WORD_BITS = 64,
    localparam int BIT_W = $clog2(WORD_BITS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [IDX_W-1:0] i_dividend,
    output logic             o_done,
    output logic [IDX_W-1:0] o_quot,
    output logic [BIT_W-1:0] o_rem
);

    // floor(x / WORD_BITS) equals (x * RECIP_L) >> SHIFT for every IDX_W-bit x
    localparam int     SHIFT   = IDX_W + BIT_W + 1;
    localparam int     PW      = IDX_W + SHIFT;
    localparam int     BW      = IDX_W + BIT_W + 1;
    localparam longint RECIP_L = ((longint'(1) << SHIFT) + longint'(WORD_BITS) - 1)
                                 / longint'(WORD_BITS);

    logic             r_busy;
    logic             r_done;
    logic [IDX_W-1:0] r_dvd;
    logic [IDX_W-1:0] r_quo;
    logic [BIT_W-1:0] r_rem;

    logic [PW-1:0]    prod;
    logic [BW-1:0]    back;
    logic [BW-1:0]    rem_full;

    assign prod     = PW'(i_dividend) * PW'(RECIP_L);
    assign back     = BW'(r_quo) * BW'(WORD_BITS);
    assign rem_full = BW'(r_dvd) - back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    // quotient registered on start, remainder registered from it while busy
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_quo <= prod[PW-1:SHIFT];
        end
        if (r_busy) begin
            r_rem <= rem_full[BIT_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

>>> rtl/bsc_word_eval.sv
// ----------------------------------------------------------------------------
// bsc_word_eval
// masks one stored word, finds its lowest candidate bit and counts its ones
// ----------------------------------------------------------------------------
module bsc_word_eval #(
    parameter int WORD_BITS = 64,
    localparam int BIT_W = $clog2(WORD_BITS),
    localparam int CNT_W = $clog2(WORD_BITS + 1)
) (
    input  logic [WORD_BITS-1:0] i_word,
    input  logic                 i_invert,
    input  logic [BIT_W-1:0]     i_lo,
    input  logic [CNT_W-1:0]     i_avail,
    output logic                 o_hit,
    output logic [BIT_W-1:0]     o_hit_pos,
    output logic [CNT_W-1:0]     o_pop
);

    logic [WORD_BITS-1:0] in_range;
    logic [WORD_BITS-1:0] cand;
    logic [WORD_BITS-1:0] lowest;

    // bit j takes part when lo <= j < avail
    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            in_range[j] = (j >= int'(i_lo)) && (j < int'(i_avail));
        end
    end

    assign cand   = (i_invert ? ~i_word : i_word) & in_range;
    assign lowest = cand & (~cand + {{(WORD_BITS-1){1'b0}}, 1'b1});
    assign o_hit  = |cand;
    assign o_pop  = CNT_W'($countones(cand));

    // one-hot to binary
    always_comb begin
        o_hit_pos = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            if (lowest[j]) begin
                o_hit_pos = o_hit_pos | BIT_W'(j);
            end
        end
    end

endmodule

>>> rtl/bitmap_set_clear_find_engine.sv
// ----------------------------------------------------------------------------
// bitmap_set_clear_find_engine
// bitmap store with test, set, clear, find-next and population count
// ----------------------------------------------------------------------------
// Channels: i_req takes one request item (action, bit_index, byte_count),
// o_rsp returns exactly one result item per request, i_cfg writes
// bitmap_size and is always ready.
// After reset the block runs a clearing pass over all NUM_WORDS words, one word
// per cycle, during which i_req is held not ready; i_cfg is taken as usual.
// One request is in flight at a time. Test, set and clear first split the bit
// index into word and bit in the reciprocal-multiply unit, then do a
// read-modify-write of the word memory. Find splits its offset the same way
// and count starts at word zero; both then scan one word per cycle through
// the single memory read port (find starts at the word of the offset and
// stops at the first match or at bitmap_size, count scans the words covering
// byte_count bytes).
// A find with an offset at or past bitmap_size, a count of zero bytes and an
// unused action go straight to the result stage without using the memory.
// The result sits in an output register; a stalled receiver holds it there
// while the next request is already accepted and worked on, and that one's
// result waits until the register is free.
// ----------------------------------------------------------------------------
`include "bitmap_set_clear_find_engine_assert.svh"

module bitmap_set_clear_find_engine import bsc_pkg::*; #(
    parameter int WORD_BITS = 64,
    parameter int NUM_WORDS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bsc_stream_if.sink    i_cfg,
    bsc_stream_if.sink    i_req,
    bsc_stream_if.source  o_rsp
);

    localparam int AW         = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int CNT_W      = $clog2(WORD_BITS + 1);
    localparam int TOTAL_BITS = NUM_WORDS * WORD_BITS;
    localparam int POS_W      = $clog2(TOTAL_BITS + (1 << SIZE_W) + WORD_BITS);

    t_state             r_state, n_state;
    logic [ACT_W-1:0]   r_act, n_act;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [POS_W-1:0]   r_bound, n_bound;
    logic [POS_W-1:0]   r_base, n_base;
    logic [BIT_W-1:0]   r_lo, n_lo;
    logic [AW-1:0]      r_addr, n_addr;
    logic               r_past, n_past;
    logic [SIZE_W-1:0]  r_acc, n_acc;
    t_rsp               r_res, n_res;
    t_rsp               r_out, n_out;
    logic               r_out_valid, n_out_valid;
    logic [SIZE_W-1:0]  r_size;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic                 div_start;
    logic                 div_done;
    logic [IDX_W-1:0]     div_quot;
    logic [BIT_W-1:0]     div_rem;

    logic [WORD_BITS-1:0] scan_word;
    logic [POS_W-1:0]     bound_gap;
    logic [POS_W-1:0]     base_next;
    logic [CNT_W-1:0]     avail;
    logic                 ev_hit;
    logic [BIT_W-1:0]     ev_pos;
    logic [CNT_W-1:0]     ev_pop;
    logic [SIZE_W-1:0]    byte_bits;
    logic [POS_W-1:0]     count_limit;
    logic                 req_accept;

    bsc_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bsc_div #(
        .WORD_BITS (WORD_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_req.payload.bit_index),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    bsc_word_eval #(
        .WORD_BITS (WORD_BITS)
    ) u_eval (
        .i_word    (scan_word),
        .i_invert  (r_act == ACT_FIND_ZERO),
        .i_lo      (r_lo),
        .i_avail   (avail),
        .o_hit     (ev_hit),
        .o_hit_pos (ev_pos),
        .o_pop     (ev_pop)
    );

    assign i_cfg.ready   = 1'b1;
    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;
    assign req_accept    = i_req.valid && i_req.ready;

    // words past the stored range read as zero
    assign scan_word = r_past ? '0 : ram_rdata;
    assign bound_gap = r_bound - r_base;
    assign base_next = r_base + POS_W'(WORD_BITS);
    assign avail     = (bound_gap >= POS_W'(WORD_BITS)) ? CNT_W'(WORD_BITS)
                                                        : bound_gap[CNT_W-1:0];

    assign byte_bits   = {i_req.payload.byte_count, 3'b000};
    assign count_limit = (POS_W'(byte_bits) >= POS_W'(TOTAL_BITS)) ? POS_W'(TOTAL_BITS)
                                                                   : POS_W'(byte_bits);

    always_comb begin
        n_state     = r_state;
        n_act       = r_act;
        n_idx       = r_idx;
        n_bound     = r_bound;
        n_base      = r_base;
        n_lo        = r_lo;
        n_addr      = r_addr;
        n_past      = r_past;
        n_acc       = r_acc;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = '0;
        ram_raddr   = r_addr;
        div_start   = 1'b0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                if (r_addr == AW'(NUM_WORDS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (req_accept) begin
                    n_act = i_req.payload.action;
                    n_idx = i_req.payload.bit_index;
                    n_res = '0;
                    n_acc = '0;
                    unique case (i_req.payload.action)
                        ACT_TEST, ACT_SET, ACT_CLEAR: begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end
                        ACT_FIND_SET, ACT_FIND_ZERO: begin
                            if ({1'b0, i_req.payload.bit_index} >= r_size) begin
                                n_res.found_position = r_size;
                                n_state              = S_DONE;
                            end else begin
                                div_start = 1'b1;
                                n_bound   = POS_W'(r_size);
                                n_state   = S_DIV;
                            end
                        end
                        ACT_COUNT: begin
                            if (count_limit == '0) begin
                                n_state = S_DONE;
                            end else begin
                                n_bound = count_limit;
                                n_base  = '0;
                                n_addr  = '0;
                                n_past  = 1'b0;
                                n_lo    = '0;
                                n_state = S_PRIME;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_addr = div_quot[AW-1:0];
                    n_past = int'(div_quot) >= NUM_WORDS;
                    n_lo   = div_rem;
                    n_base = POS_W'(r_idx) - POS_W'(div_rem);
                    if (r_act == ACT_FIND_SET || r_act == ACT_FIND_ZERO) begin
                        n_state = S_PRIME;
                    end else if (int'(div_quot) >= NUM_WORDS) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RMW_RD;
                    end
                end
            end
            S_RMW_RD: begin
                n_state = S_RMW_WR;
            end
            S_RMW_WR: begin
                n_res.old_bit   = ram_rdata[r_lo];
                ram_wdata       = ram_rdata;
                ram_wdata[r_lo] = (r_act == ACT_SET);
                ram_we          = (r_act == ACT_SET) || (r_act == ACT_CLEAR);
                n_state         = S_DONE;
            end
            S_PRIME: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // prefetch the following word while this one is evaluated
                ram_raddr = r_addr + 1'b1;
                if (r_act != ACT_COUNT && ev_hit) begin
                    n_res.found_position = SIZE_W'(r_base + POS_W'(ev_pos));
                    n_state              = S_DONE;
                end else if (base_next >= r_bound) begin
                    if (r_act == ACT_COUNT) begin
                        n_res.set_count = r_acc + SIZE_W'(ev_pop);
                    end else begin
                        n_res.found_position = SIZE_W'(r_bound);
                    end
                    n_state = S_DONE;
                end else begin
                    n_acc  = r_acc + SIZE_W'(ev_pop);
                    n_base = base_next;
                    n_addr = r_addr + 1'b1;
                    n_lo   = '0;
                    if (r_addr == AW'(NUM_WORDS - 1)) begin
                        n_past = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
            r_size      <= SIZE_RESET;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_size <= i_cfg.payload;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act   <= n_act;
        r_idx   <= n_idx;
        r_bound <= n_bound;
        r_base  <= n_base;
        r_lo    <= n_lo;
        r_past  <= n_past;
        r_acc   <= n_acc;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    `BSC_ASSERT_IMPLIES(a_scan_below_bound, i_clk, i_rst_n, r_state == S_SCAN, r_base < r_bound)
    `BSC_ASSERT_IMPLIES(a_write_source, i_clk, i_rst_n, ram_we, (r_state == S_CLEAR) || (r_state == S_RMW_WR))
    `BSC_ASSERT_IMPLIES(a_rmw_in_storage, i_clk, i_rst_n, r_state == S_RMW_WR, !r_past)
    `BSC_ASSERT_NEXT(a_result_from_done, i_clk, i_rst_n, (r_state != S_DONE) && !r_out_valid, !r_out_valid)

endmodule
